FILE: sv/rad_pkg.sv
// Shared types, constants and codes for the ratiometric ADC averager.
`default_nettype none
package rad_pkg;

  localparam int SAMPLE_BITS = 13;
  localparam int SUM_BITS    = 21;

  localparam int INTERVAL_W = 16;
  localparam int COUNT_W    = 8;
  localparam int GAIN_W     = 24;
  localparam int OFFSET_W   = 21;
  localparam int VOLT_W     = 32;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 2;

  localparam int QUO_W   = SUM_BITS + GAIN_W;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int VSUM_W  = VOLT_W + 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INTERVAL_MS  = 2'd0,
    REG_SAMPLE_COUNT = 2'd1,
    REG_GAIN_UV      = 2'd2,
    REG_OFFSET_UV    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] measured_sample;
    logic [SAMPLE_BITS-1:0] reference_sample;
  } in_t;

  typedef struct packed {
    logic signed [VOLT_W-1:0] voltage_uv;
    logic                     reference_zero;
  } out_t;

  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_load;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/rad_datapath.sv
// Datapath: config registers, window accumulators, multiplier, divider, output register.
`default_nettype none
module rad_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rad_pkg::ctrl_cmd_t            cmd_i,
  input  wire rad_pkg::in_t                  in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rad_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [rad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rad_pkg::dp_status_t                status_o,
  output rad_pkg::out_t                      out_data_o
);
  import rad_pkg::*;

  logic [INTERVAL_W-1:0]      interval_q;
  logic [COUNT_W-1:0]         sample_count_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [OFFSET_W-1:0] offset_q;

  logic [INTERVAL_W-1:0] tick_q, tick_d;
  logic                  wopen_q, wopen_d;
  logic [COUNT_W-1:0]    pairs_q, pairs_d;
  logic [SUM_BITS-1:0]   msum_q, msum_d;
  logic [SUM_BITS-1:0]   rsum_q, rsum_d;

  logic [QUO_W-1:0]    mul_q;
  logic [QUO_W-1:0]    quo_q;
  logic [SUM_BITS-1:0] rem_q;
  out_t                out_q;

  logic                opens;
  logic [SUM_BITS-1:0] msum_base, rsum_base;
  logic [COUNT_W-1:0]  pairs_base, pairs_new, need;
  logic [SUM_BITS:0]   msum_add, rsum_add;
  logic [SUM_BITS-1:0] msum_new, rsum_new;
  logic                closes;

  logic [SUM_BITS:0]   rem_sh, rem_diff;
  logic                rem_ge;

  logic [VOLT_W:0]            q_clamp;
  logic signed [VSUM_W-1:0]   v_sum;
  logic signed [VOLT_W-1:0]   v_sat;

  localparam logic [VOLT_W:0] QMAX = {1'b1, {VOLT_W{1'b0}}};
  localparam logic signed [VSUM_W-1:0] VMAX =
    {{(VSUM_W-VOLT_W+1){1'b0}}, {(VOLT_W-1){1'b1}}};
  localparam logic signed [VSUM_W-1:0] VMIN =
    {{(VSUM_W-VOLT_W+1){1'b1}}, {(VOLT_W-1){1'b0}}};

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q     <= '0;
      sample_count_q <= COUNT_W'(150);
      gain_q         <= GAIN_W'(1222434);
      offset_q       <= OFFSET_W'(22255);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_INTERVAL_MS:  interval_q     <= cfg_data_i[INTERVAL_W-1:0];
        REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_GAIN_UV:      gain_q         <= cfg_data_i[GAIN_W-1:0];
        REG_OFFSET_UV:    offset_q       <= signed'(cfg_data_i[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // window step
  always_comb begin
    opens      = wopen_q || (tick_q >= interval_q);
    msum_base  = wopen_q ? msum_q : '0;
    rsum_base  = wopen_q ? rsum_q : '0;
    pairs_base = wopen_q ? pairs_q : '0;
    msum_add   = {1'b0, msum_base} + (SUM_BITS+1)'(in_data_i.measured_sample);
    rsum_add   = {1'b0, rsum_base} + (SUM_BITS+1)'(in_data_i.reference_sample);
    msum_new   = msum_add[SUM_BITS] ? '1 : msum_add[SUM_BITS-1:0];
    rsum_new   = rsum_add[SUM_BITS] ? '1 : rsum_add[SUM_BITS-1:0];
    pairs_new  = (pairs_base == '1) ? pairs_base : pairs_base + COUNT_W'(1);
    need       = (sample_count_q == '0) ? COUNT_W'(1) : sample_count_q;
    closes     = in_data_i.cmd && opens && (pairs_new >= need);

    tick_d  = tick_q;
    wopen_d = wopen_q;
    pairs_d = pairs_q;
    msum_d  = msum_q;
    rsum_d  = rsum_q;
    if (cmd_i.accept) begin
      if (!in_data_i.cmd) begin
        if (!wopen_q && (tick_q != '1)) begin
          tick_d = tick_q + INTERVAL_W'(1);
        end
      end else if (opens) begin
        msum_d = msum_new;
        rsum_d = rsum_new;
        if (closes) begin
          wopen_d = 1'b0;
          pairs_d = '0;
          tick_d  = '0;
        end else begin
          wopen_d = 1'b1;
          pairs_d = pairs_new;
        end
      end
    end
  end

  assign status_o.close = closes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      wopen_q <= 1'b0;
      pairs_q <= '0;
      msum_q  <= '0;
      rsum_q  <= '0;
    end else begin
      tick_q  <= tick_d;
      wopen_q <= wopen_d;
      pairs_q <= pairs_d;
      msum_q  <= msum_d;
      rsum_q  <= rsum_d;
    end
  end

  // restoring division, one quotient bit per step
  always_comb begin
    rem_sh   = {rem_q, quo_q[QUO_W-1]};
    rem_ge   = rem_sh >= {1'b0, rsum_q};
    rem_diff = rem_sh - {1'b0, rsum_q};
  end

  // clamp, add offset, saturate
  always_comb begin
    q_clamp = (quo_q > QUO_W'(QMAX)) ? QMAX : quo_q[VOLT_W:0];
    v_sum   = signed'(VSUM_W'(q_clamp)) + VSUM_W'(offset_q);
    if (v_sum > VMAX) begin
      v_sat = VMAX[VOLT_W-1:0];
    end else if (v_sum < VMIN) begin
      v_sat = VMIN[VOLT_W-1:0];
    end else begin
      v_sat = v_sum[VOLT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mul_q <= QUO_W'(msum_q * gain_q);
    end
    if (cmd_i.div_load) begin
      quo_q <= mul_q + QUO_W'(rsum_q >> 1);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_diff[SUM_BITS-1:0] : rem_sh[SUM_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      if (rsum_q == '0) begin
        out_q.voltage_uv     <= '0;
        out_q.reference_zero <= 1'b1;
      end else begin
        out_q.voltage_uv     <= v_sat;
        out_q.reference_zero <= 1'b0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

FILE: sv/rad_ctrl.sv
// Controller: sequences request intake, multiply, divide and result handoff.
`default_nettype none
module rad_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire rad_pkg::dp_status_t status_i,
  output rad_pkg::ctrl_cmd_t       cmd_o
);
  import rad_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.close) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    step_d     = step_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL:  cmd_o.mul_load = 1'b1;
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
      end
      ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_close_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && status_i.close) |=> state_q == ST_MUL)
    else $error("closing request did not start the multiply");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == LAST_STEP) |=> state_q == ST_DONE)
    else $error("divider did not finish after its last step");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised without a finished division");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register loaded while a stalled result waits");

endmodule
`default_nettype wire

FILE: sv/ratiometric_adc_averager.sv
// Top level of the ratiometric ADC averager.
// Input channel (in_valid_i / in_stall_o / in_data_i): each request is a
// millisecond tick (cmd = 0) or a measured/reference sample pair (cmd = 1).
// A tick or a pair that does not end a window is taken without stalling the input.
// The pair that ends a window starts a 21x24 multiply, a rounding add and a
// restoring divide with one quotient bit per cycle (45 steps); the input
// stalls meanwhile. The result is registered when the division ends and the
// output register is free.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// window. While the receiver stalls, the result holds and ticks and pairs
// keep being taken; a finished division waits until the result is taken.
// Config port (cfg_we_i / cfg_addr_i / cfg_data_i): write only while idle.
// Reset restores the register defaults, closes any window and clears the
// tick count.
`default_nettype none
module ratiometric_adc_averager (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire rad_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output rad_pkg::out_t                       out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rad_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [rad_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rad_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rad_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ratiometric ADC averager: directed and random requests.
module tb_top;
  import rad_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1222434;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 21'sd22255;
  localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
  localparam longint VOLT_MAX = 64'sd2147483647;
  localparam longint VOLT_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int err_cnt = 0;
  int taken_reqs = 0;

  logic [INTERVAL_W-1:0] interval_set = '0;
  logic [COUNT_W-1:0] count_set = 8'd150;
  logic [GAIN_W-1:0] gain_set = GAIN_RESET;
  logic signed [OFFSET_W-1:0] offset_set = OFFSET_RESET;
  logic [INTERVAL_W-1:0] tick_cnt = '0;
  logic win_open = 1'b0;
  logic [COUNT_W-1:0] pairs_cnt = '0;
  logic [SUM_BITS-1:0] meas_acc = '0;
  logic [SUM_BITS-1:0] ref_acc = '0;
  out_t voltage_q[$];

  always #5 clk = ~clk;

  ratiometric_adc_averager dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] acc,
                                                 input logic [SAMPLE_BITS-1:0] sample);
    logic [SUM_BITS:0] total;
    total = acc + sample;
    return total[SUM_BITS] ? {SUM_BITS{1'b1}} : total[SUM_BITS-1:0];
  endfunction

  function automatic out_t window_voltage();
    out_t res;
    longint unsigned num;
    longint unsigned quo;
    longint volt;
    res = '0;
    if (ref_acc == '0) begin
      res.reference_zero = 1'b1;
    end else begin
      num = meas_acc;
      num = num * gain_set;
      quo = (num + (ref_acc >> 1)) / ref_acc;
      if (quo > 64'h1_0000_0000) quo = 64'h1_0000_0000;
      volt = longint'(quo) + longint'(offset_set);
      if (volt > VOLT_MAX) volt = VOLT_MAX;
      if (volt < VOLT_MIN) volt = VOLT_MIN;
      res.voltage_uv = volt[VOLT_W-1:0];
    end
    return res;
  endfunction

  function automatic void accumulate_request(input in_t req);
    logic [COUNT_W-1:0] need;
    if (!req.cmd) begin
      if (!win_open && tick_cnt != '1) begin
        tick_cnt++;
      end
    end else if (win_open || tick_cnt >= interval_set) begin
      if (!win_open) begin
        win_open = 1'b1;
        pairs_cnt = '0;
        meas_acc = '0;
        ref_acc = '0;
      end
      meas_acc = sat_sum(meas_acc, req.measured_sample);
      ref_acc = sat_sum(ref_acc, req.reference_sample);
      if (pairs_cnt != '1) pairs_cnt++;
      need = (count_set == '0) ? 8'd1 : count_set;
      if (pairs_cnt >= need) begin
        voltage_q.push_back(window_voltage());
        win_open = 1'b0;
        pairs_cnt = '0;
        tick_cnt = '0;
      end
    end
  endfunction

  function automatic in_t pair_req(input logic [SAMPLE_BITS-1:0] meas,
                                   input logic [SAMPLE_BITS-1:0] refv);
    in_t req;
    req.cmd = 1'b1;
    req.measured_sample = meas;
    req.reference_sample = refv;
    return req;
  endfunction

  function automatic in_t tick_req();
    in_t req;
    req.cmd = 1'b0;
    req.measured_sample = SAMPLE_BITS'($urandom);
    req.reference_sample = SAMPLE_BITS'($urandom);
    return req;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return SAMPLE_BITS'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic in_t rand_req(input bit zero_ref);
    in_t req;
    int unsigned pick;
    pick = $urandom_range(99);
    req = pair_req(rand_sample(), rand_sample());
    if (zero_ref && $urandom_range(9) != 0) req.reference_sample = '0;
    if (!win_open && tick_cnt < interval_set) req.cmd = (pick < 15);
    else req.cmd = (pick < 85);
    return req;
  endfunction

  function automatic void note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Called and returns at a falling edge; valid stays high for a following request.
  task automatic send_req(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    taken_reqs++;
    accumulate_request(req);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (voltage_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [INTERVAL_W-1:0] interval,
                              input logic [COUNT_W-1:0] count,
                              input logic [GAIN_W-1:0] gain,
                              input logic signed [OFFSET_W-1:0] offset);
    cfg_we <= 1'b1;
    cfg_addr <= REG_INTERVAL_MS;
    cfg_data <= CFG_DATA_W'(interval);
    @(negedge clk);
    cfg_addr <= REG_SAMPLE_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    @(negedge clk);
    cfg_addr <= REG_GAIN_UV;
    cfg_data <= CFG_DATA_W'(gain);
    @(negedge clk);
    cfg_addr <= REG_OFFSET_UV;
    cfg_data <= CFG_DATA_W'(offset);
    @(negedge clk);
    cfg_we <= 1'b0;
    interval_set = interval;
    count_set = count;
    gain_set = gain;
    offset_set = offset;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    repeat (150) send_req(pair_req(rand_sample(), rand_sample()));
    settle_block();
  endtask

  task automatic test_extremes();
    program_regs('0, 8'd1, GAIN_MAX, OFFSET_MAX);
    send_req(pair_req(SAMPLE_MAX, 13'd1));
    send_req(pair_req('0, SAMPLE_MAX));
    send_req(pair_req(SAMPLE_MAX, SAMPLE_MAX));
    send_req(pair_req('0, '0));
    send_req(pair_req(13'd1, 13'd2));
    settle_block();
    program_regs('0, '0, '0, OFFSET_MIN);
    send_req(pair_req(SAMPLE_MAX, SAMPLE_MAX));
    send_req(pair_req(13'd123, '0));
    settle_block();
    program_regs('0, '1, GAIN_RESET, -21'sd1000000);
    repeat (255) send_req(pair_req(SAMPLE_MAX, SAMPLE_MAX));
    settle_block();
  endtask

  task automatic test_ticks_and_gaps();
    program_regs(16'd4, 8'd2, GAIN_RESET, 21'sd1000000);
    send_req(pair_req(13'd100, 13'd200));
    repeat (3) send_req(tick_req());
    send_req(pair_req(13'd300, 13'd400));
    send_req(tick_req());
    send_req(pair_req(13'd4000, 13'd5000));
    send_req(tick_req());
    send_req(pair_req(13'd7000, 13'd6000));
    send_req(pair_req(13'd50, 13'd60));
    repeat (4) send_req(tick_req());
    send_req(pair_req(13'd1, SAMPLE_MAX));
    send_req(pair_req(SAMPLE_MAX, 13'd1));
    settle_block();
  endtask

  task automatic test_count_lowered();
    program_regs('0, 8'd10, GAIN_RESET, OFFSET_RESET);
    repeat (5) send_req(pair_req(rand_sample(), rand_sample()));
    settle_block();
    program_regs('0, 8'd3, GAIN_RESET, OFFSET_RESET);
    send_req(pair_req(rand_sample(), rand_sample()));
    settle_block();
  endtask

  task automatic test_long_interval();
    program_regs(16'd40, 8'd1, GAIN_RESET, OFFSET_RESET);
    repeat (39) send_req(tick_req());
    send_req(pair_req(13'd2000, 13'd3000));
    send_req(tick_req());
    send_req(pair_req(13'd2000, 13'd3000));
    repeat (3) send_req(tick_req());
    send_req(pair_req(13'd2000, 13'd3000));
    settle_block();
  endtask

  task automatic test_backpressure();
    program_regs('0, 8'd1, GAIN_RESET, OFFSET_RESET);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (40) send_req(pair_req(rand_sample(), rand_sample()));
    settle_block();
  endtask

  task automatic random_traffic(input int idle_pct, input int stall_pct, input int target);
    int start;
    int n;
    bit zero_ref;
    logic [INTERVAL_W-1:0] interval;
    logic [COUNT_W-1:0] count;
    logic [GAIN_W-1:0] gain;
    logic signed [OFFSET_W-1:0] offset;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = taken_reqs;
    while (taken_reqs - start < target) begin
      settle_block();
      case ($urandom_range(9))
        0, 1, 2, 3: interval = '0;
        9: interval = INTERVAL_W'($urandom_range(13, 60));
        default: interval = INTERVAL_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(19))
        0: count = '1;
        1: count = '0;
        2, 3, 4: count = COUNT_W'($urandom_range(6, 40));
        default: count = COUNT_W'($urandom_range(1, 5));
      endcase
      case ($urandom_range(7))
        0: gain = '0;
        1: gain = GAIN_MAX;
        default: gain = GAIN_W'($urandom);
      endcase
      case ($urandom_range(7))
        0: offset = OFFSET_MIN;
        1: offset = OFFSET_MAX;
        2: offset = -21'sd1000000;
        3: offset = 21'sd1000000;
        default: offset = OFFSET_W'($urandom);
      endcase
      program_regs(interval, count, gain, offset);
      zero_ref = ($urandom_range(5) == 0);
      n = $urandom_range(30, 90);
      repeat (n) send_req(rand_req(zero_ref));
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (voltage_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: voltage_uv %0d reference_zero %0b",
                                out_data.voltage_uv, out_data.reference_zero));
      end else begin
        want = voltage_q.pop_front();
        if (out_data.voltage_uv !== want.voltage_uv)
          note_mismatch($sformatf("voltage_uv: expected %0d, got %0d",
                                  want.voltage_uv, out_data.voltage_uv));
        if (out_data.reference_zero !== want.reference_zero)
          note_mismatch($sformatf("reference_zero: expected %0b, got %0b",
                                  want.reference_zero, out_data.reference_zero));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ratiometric_adc_averager: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 10;
    recv_stall_pct = 73;
    test_reset_defaults();
    test_extremes();
    test_ticks_and_gaps();
    test_count_lowered();
    test_long_interval();
    test_backpressure();
    random_traffic(10, 73, 360);
    random_traffic(73, 10, 360);
    random_traffic(0, 0, 360);
    settle_block();
    if (err_cnt == 0) begin
      $display("ratiometric_adc_averager: match");
    end else begin
      $display("ratiometric_adc_averager: mismatch");
    end
    $finish;
  end

endmodule
